@@ rtl/svpd_pkg.sv @@
package svpd_pkg;

    localparam int DIV_STEPS   = 28;
    localparam int QUEUE_DEPTH = 4;
    localparam int W_T         = 40;
    localparam int W_D         = 44;

    localparam logic [15:0] PERIOD_RESET = 16'd8500;
    localparam logic [31:0] GAIN_RESET   = 32'd65536;
    localparam logic [31:0] RECIP_RESET  = 32'd505290;

    localparam logic [1:0] CFG_PERIOD = 2'd0;
    localparam logic [1:0] CFG_GAIN   = 2'd1;
    localparam logic [1:0] CFG_RECIP  = 2'd2;

    localparam logic [1:0] LEG_A = 2'd0;
    localparam logic [1:0] LEG_B = 2'd1;
    localparam logic [1:0] LEG_C = 2'd2;

    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;
    localparam logic [2:0] SECTOR_6 = 3'd6;
    localparam logic [2:0] SECTOR_7 = 3'd7;
    localparam logic [2:0] SECTOR_0 = 3'd0;

    typedef struct packed {
        logic signed [15:0] v_alpha;
        logic signed [15:0] v_beta;
    } t_in;

    typedef struct packed {
        logic [15:0] duty_phase_a;
        logic [15:0] duty_phase_b;
        logic [15:0] duty_phase_c;
        logic [2:0]  sector_number;
        logic        overmodulated;
    } t_out;

    typedef struct packed {
        logic [15:0] period_ticks;
        logic [31:0] voltage_gain;
        logic [31:0] reciprocal_period;
    } t_cfg;

    typedef struct packed {
        logic signed [W_T-1:0] m;
        logic signed [W_T-1:0] s;
        logic [2:0]            sector;
    } t_mid;

    // leg chosen for each phase, index 0 is phase a
    function automatic logic [2:0][1:0] leg_map(input logic [2:0] sector);
        logic [2:0][1:0] r;
        unique case (sector)
            SECTOR_1: r = {LEG_C, LEG_A, LEG_B};
            SECTOR_2: r = {LEG_B, LEG_C, LEG_A};
            SECTOR_3: r = {LEG_C, LEG_B, LEG_A};
            SECTOR_4: r = {LEG_A, LEG_B, LEG_C};
            SECTOR_5: r = {LEG_B, LEG_A, LEG_C};
            default:  r = {LEG_A, LEG_C, LEG_B};
        endcase
        return r;
    endfunction

endpackage

@@ rtl/svpd_front.sv @@
module svpd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  svpd_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  svpd_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output svpd_pkg::t_mid  o_mid
);
    localparam int W_T = svpd_pkg::W_T;

    logic en;
    logic r_v1, r_v2, r_v3;
    logic [2:0] r_code1, r_code2;
    logic signed [34:0] r_qx, r_qy, r_qz;
    logic signed [51:0] r_px, r_py, r_pz;
    svpd_pkg::t_mid r_mid;

    logic signed [34:0] ka, kb, qx, qy, qz;
    logic signed [35:0] t2, t4;
    logic [2:0] code;
    logic signed [18:0] vx, vy, vz;
    logic signed [W_T-1:0] tx, ty, tz, m, s;

    assign en      = !r_v3 || i_ready;
    assign o_ready = en;
    assign o_valid = r_v3;
    assign o_mid   = r_mid;

    // sector from three sign tests and the exact q31 vector terms
    always_comb begin
        ka = 35'(i_data.v_alpha) * 35'sd113512;
        kb = 35'(i_data.v_beta) <<< 16;
        t2 = 36'(ka) - 36'(kb);
        t4 = -36'(ka) - 36'(kb);
        code = {t4 > 36'sd0, t2 > 36'sd0, i_data.v_beta > 16'sd0};
        if (code == svpd_pkg::SECTOR_0 || code == svpd_pkg::SECTOR_7) begin
            code = svpd_pkg::SECTOR_6;
        end
        qx = 35'(i_data.v_beta) * 35'sd113512;
        qy = 35'(i_data.v_alpha) * 35'sd98304 + 35'(i_data.v_beta) * 35'sd56756;
        qz = 35'(i_data.v_beta) * 35'sd56756 - 35'(i_data.v_alpha) * 35'sd98304;
    end

    always_comb begin
        vx = 19'((r_qx + 35'sd32768) >>> 16);
        vy = 19'((r_qy + 35'sd32768) >>> 16);
        vz = 19'((r_qz + 35'sd32768) >>> 16);
    end

    always_comb begin
        tx = W_T'((r_px + 52'sd16384) >>> 15);
        ty = W_T'((r_py + 52'sd16384) >>> 15);
        tz = W_T'((r_pz + 52'sd16384) >>> 15);
        unique case (r_code2)
            svpd_pkg::SECTOR_1: begin m = tz;  s = ty;  end
            svpd_pkg::SECTOR_2: begin m = ty;  s = -tx; end
            svpd_pkg::SECTOR_3: begin m = -tz; s = tx;  end
            svpd_pkg::SECTOR_4: begin m = -tx; s = tz;  end
            svpd_pkg::SECTOR_5: begin m = tx;  s = -ty; end
            default:            begin m = -ty; s = -tz; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_code1 <= code;
            r_qx    <= qx;
            r_qy    <= qy;
            r_qz    <= qz;
            r_code2 <= r_code1;
            r_px    <= 52'(vx) * $signed(52'(i_cfg.voltage_gain));
            r_py    <= 52'(vy) * $signed(52'(i_cfg.voltage_gain));
            r_pz    <= 52'(vz) * $signed(52'(i_cfg.voltage_gain));
            r_mid.m      <= m;
            r_mid.s      <= s;
            r_mid.sector <= r_code2;
        end
    end

endmodule

@@ rtl/svpd_fifo.sv @@
module svpd_fifo #(
    parameter int DEPTH = svpd_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  svpd_pkg::t_mid  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output svpd_pkg::t_mid  o_data,
    output logic            o_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    svpd_pkg::t_mid r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic do_push, do_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/svpd_back.sv @@
module svpd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  svpd_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  svpd_pkg::t_mid  i_mid,
    output logic            o_valid,
    input  logic            i_ready,
    output svpd_pkg::t_out  o_data
);
    localparam int W_T = svpd_pkg::W_T;
    localparam int W_D = svpd_pkg::W_D;
    localparam int NS  = svpd_pkg::DIV_STEPS;

    typedef struct packed {
        logic signed [W_T-1:0] m;
        logic signed [W_T-1:0] s;
        logic signed [W_T-1:0] sum;
        logic                  ovm;
        logic [2:0]            sector;
        logic [W_T-1:0]        rem;
        logic [NS:0]           q;
    } t_dst;

    logic en;
    logic [NS:0] r_dvv;
    t_dst r_dv [NS+1];
    logic r_mv, r_lv, r_pv, r_ov;
    logic signed [W_T-1:0] r_mm, r_ms;
    logic r_movm, r_lovm, r_povm;
    logic [2:0] r_msec, r_lsec, r_psec;
    logic [44:0] r_prod;
    logic [2:0][20:0] r_hi;
    logic [2:0][19:0] r_lo;
    logic [2:0][52:0] r_ph;
    logic [2:0][51:0] r_pl;
    svpd_pkg::t_out r_out;

    logic signed [W_T-1:0] tq, sum0, mc;
    logic q0;
    logic [W_T-1:0] w_r2 [NS+1];
    logic w_ge [NS+1];
    logic signed [W_T-1:0] mo, so;
    logic signed [W_D-1:0] lg [3];
    logic signed [W_D-1:0] d;
    logic [40:0] ud;
    logic [2:0][1:0] sel;
    logic [2:0][20:0] hi;
    logic [2:0][19:0] lo;
    logic [2:0][15:0] duty;
    logic [53:0] qq;
    logic [40:0] q13;

    assign en      = !r_ov || i_ready;
    assign o_ready = en;
    assign o_valid = r_ov;
    assign o_data  = r_out;
    assign tq      = $signed(W_T'({i_cfg.period_ticks, 16'd0}));

    // overmodulation test, clamp and the first quotient bit
    always_comb begin
        sum0 = i_mid.m + i_mid.s;
        if (i_mid.m < 0) begin
            mc = '0;
        end else if (i_mid.m > sum0) begin
            mc = sum0;
        end else begin
            mc = i_mid.m;
        end
        q0 = mc == sum0;
    end

    // one quotient bit a stage, remainder stays below the divisor
    always_comb begin
        w_r2[0] = '0;
        w_ge[0] = 1'b0;
        for (int k = 1; k <= NS; k++) begin
            w_r2[k] = {r_dv[k-1].rem[W_T-2:0], 1'b0};
            w_ge[k] = w_r2[k] >= $unsigned(r_dv[k-1].sum);
        end
    end

    always_comb begin
        mo = r_movm ? $signed(W_T'(r_prod >> 12)) : r_mm;
        so = r_movm ? tq - mo : r_ms;
        lg[0] = W_D'(tq) - W_D'(mo) - W_D'(so);
        lg[1] = lg[0] + (W_D'(mo) <<< 1);
        lg[2] = lg[1] + (W_D'(so) <<< 1);
        sel = svpd_pkg::leg_map(r_msec);
        d  = '0;
        ud = '0;
        for (int k = 0; k < 3; k++) begin
            d = (W_D'(tq) <<< 1) - lg[sel[k]];
            if (d <= 0) begin
                ud = '0;
            end else if (d > $signed(W_D'(41'h100_0000_0000))) begin
                ud = 41'h100_0000_0000;
            end else begin
                ud = d[40:0];
            end
            hi[k] = ud[40:20];
            lo[k] = ud[19:0];
        end
    end

    always_comb begin
        qq  = '0;
        q13 = '0;
        for (int k = 0; k < 3; k++) begin
            qq  = 54'(r_ph[k]) + 54'(r_pl[k] >> 20);
            q13 = 41'(qq >> 13);
            duty[k] = (q13 > 41'd65535) ? 16'hffff : q13[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv <= '0;
            r_mv  <= 1'b0;
            r_lv  <= 1'b0;
            r_pv  <= 1'b0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r_dvv <= {r_dvv[NS-1:0], i_valid};
            r_mv  <= r_dvv[NS];
            r_lv  <= r_mv;
            r_pv  <= r_lv;
            r_ov  <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0].m      <= i_mid.m;
            r_dv[0].s      <= i_mid.s;
            r_dv[0].sum    <= sum0;
            r_dv[0].ovm    <= sum0 > tq;
            r_dv[0].sector <= i_mid.sector;
            r_dv[0].rem    <= q0 ? '0 : mc;
            r_dv[0].q      <= (NS+1)'(q0);
            for (int k = 1; k <= NS; k++) begin
                r_dv[k].m      <= r_dv[k-1].m;
                r_dv[k].s      <= r_dv[k-1].s;
                r_dv[k].sum    <= r_dv[k-1].sum;
                r_dv[k].ovm    <= r_dv[k-1].ovm;
                r_dv[k].sector <= r_dv[k-1].sector;
                r_dv[k].rem    <= w_ge[k] ? w_r2[k] - $unsigned(r_dv[k-1].sum) : w_r2[k];
                r_dv[k].q      <= {r_dv[k-1].q[NS-1:0], w_ge[k]};
            end
            r_mm   <= r_dv[NS].m;
            r_ms   <= r_dv[NS].s;
            r_movm <= r_dv[NS].ovm;
            r_msec <= r_dv[NS].sector;
            r_prod <= 45'(r_dv[NS].q) * 45'(i_cfg.period_ticks);
            r_lovm <= r_movm;
            r_lsec <= r_msec;
            r_hi   <= hi;
            r_lo   <= lo;
            r_povm <= r_lovm;
            r_psec <= r_lsec;
            for (int k = 0; k < 3; k++) begin
                r_ph[k] <= 53'(r_hi[k]) * 53'(i_cfg.reciprocal_period);
                r_pl[k] <= 52'(r_lo[k]) * 52'(i_cfg.reciprocal_period);
            end
            r_out.duty_phase_a  <= duty[0];
            r_out.duty_phase_b  <= duty[1];
            r_out.duty_phase_c  <= duty[2];
            r_out.sector_number <= r_psec;
            r_out.overmodulated <= r_povm;
        end
    end

endmodule

@@ rtl/space_vector_pwm_duty.sv @@
// channel   direction  handshake             payload
// request   in         i_valid / o_ready     i_data  (t_in: v_alpha, v_beta)
// result    out        o_valid / i_ready     o_data  (t_out: duties, sector, flag)
// config    in         i_cfg_we              i_cfg_index, i_cfg_data
//
// one request enters every cycle while o_ready is high; the path is 3 front stages, the queue
// and 33 back stages, 28 of them the bit-per-stage steps of the rescale divider
// synchronous active-low reset clears all valid flags and the queue pointers
// the back stalls as one when a result waits; the queue then absorbs the front
module space_vector_pwm_duty #(
    parameter int QUEUE_DEPTH = svpd_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  svpd_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output svpd_pkg::t_out  o_data,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data
);
    svpd_pkg::t_cfg r_cfg;
    svpd_pkg::t_mid f_mid, q_mid;
    logic f_valid, q_full, q_empty, b_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_ticks      <= svpd_pkg::PERIOD_RESET;
            r_cfg.voltage_gain      <= svpd_pkg::GAIN_RESET;
            r_cfg.reciprocal_period <= svpd_pkg::RECIP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                svpd_pkg::CFG_PERIOD: r_cfg.period_ticks      <= i_cfg_data[15:0];
                svpd_pkg::CFG_GAIN:   r_cfg.voltage_gain      <= i_cfg_data;
                svpd_pkg::CFG_RECIP:  r_cfg.reciprocal_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    svpd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (f_valid),
        .i_ready (!q_full),
        .o_mid   (f_mid)
    );

    svpd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_mid),
        .o_full  (q_full),
        .i_pop   (b_ready),
        .o_data  (q_mid),
        .o_empty (q_empty)
    );

    svpd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (!q_empty),
        .o_ready (b_ready),
        .i_mid   (q_mid),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

@@ rtl/svpd_checker.sv @@
module svpd_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_valid,
    input logic            i_ready,
    input svpd_pkg::t_out  o_data
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_data))
        else $error("result changed while stalled");

    a_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.sector_number != svpd_pkg::SECTOR_0
                 && o_data.sector_number != svpd_pkg::SECTOR_7)
        else $error("sector out of range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind space_vector_pwm_duty svpd_checker u_chk (.*);
